FILE: sv/tbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_pkg
// Shared types and constants of the text buffer edit engine.
// ----------------------------------------------------------------------------
package tbe_pkg;

	localparam int CHAR_W    = 8;
	localparam int PACK_W    = 64;
	localparam int LEN_W     = 11;
	localparam int POS_W     = 10;
	localparam int CNT_W     = 4;

	typedef enum logic [2:0] {
		MODE_WRITE   = 3'd0,
		MODE_READ    = 3'd1,
		MODE_INSERT  = 3'd2,
		MODE_DELETE  = 3'd3,
		MODE_REPLACE = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_SEARCH,
		ST_PREP,
		ST_SHIFT,
		ST_FILL
	} state_t;

endpackage

FILE: sv/tbe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_ram
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tbe_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [tbe_pkg::CHAR_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [tbe_pkg::CHAR_W-1:0]  rdata
);

	logic [tbe_pkg::CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/tbe_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbe_match
// Compares the sliding window of recently read characters with the pattern.
// ----------------------------------------------------------------------------
module tbe_match #(
	parameter int PM = 8
) (
	input  logic [PM*tbe_pkg::CHAR_W-1:0] win,
	input  logic [tbe_pkg::PACK_W-1:0]    pat,
	input  logic [tbe_pkg::CNT_W-1:0]     plen,
	input  logic [tbe_pkg::CNT_W-1:0]     cnt,
	output logic                          hit
);

	logic [tbe_pkg::CNT_W-1:0] idx;

	// window byte 0 is the newest, so it lines up with the last pattern byte
	always_comb begin
		idx = '0;
		hit = (cnt >= plen) && (plen != '0);
		for (int m = 0; m < PM; m++) begin
			idx = plen - tbe_pkg::CNT_W'(m) - tbe_pkg::CNT_W'(1);
			if (tbe_pkg::CNT_W'(m) < plen) begin
				if (win[m*tbe_pkg::CHAR_W +: tbe_pkg::CHAR_W] !=
					pat[{idx[2:0], 3'b000} +: tbe_pkg::CHAR_W]) begin
					hit = 1'b0;
				end
			end
		end
	end

endmodule

FILE: sv/text_buffer_edit_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_buffer_edit_engine_top
// Fixed-length character store with write, read, insert, delete-first and
// replace-first commands, one command at a time.
// ----------------------------------------------------------------------------
// steps: write, unknown mode, empty replace pattern and read or insert
//   beyond L finish straight from idle; read waits for the registered RAM
//   data; delete and replace search from position, then shift the tail and
//   fill the replacement, or end with no hit; insert skips the search
// throughput: one command at a time, next start taken the cycle busy drops
// reset: a clearing pass over all BUFFER_DEPTH entries zeroes the store, busy high
// results are strobed by done for one cycle; the receiver cannot stall
module text_buffer_edit_engine_top #(
	parameter int BUFFER_DEPTH = 1024,
	parameter int PATTERN_MAX  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [9:0]  position,
	input  logic [7:0]  char_value,
	input  logic [63:0] pattern,
	input  logic [3:0]  pattern_length,
	input  logic [63:0] replacement,
	input  logic [3:0]  replacement_length,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic        done,
	output logic [7:0]  read_char,
	output logic        succeeded,
	output logic [10:0] end_position
);

	localparam int AW  = $clog2(BUFFER_DEPTH);
	localparam int NW  = ((AW + 1) > tbe_pkg::LEN_W ? (AW + 1) : tbe_pkg::LEN_W) + 1;
	localparam int CW  = tbe_pkg::CHAR_W;
	localparam int PW  = tbe_pkg::PACK_W;
	localparam int KW  = tbe_pkg::CNT_W;

	tbe_pkg::state_t state_q, state_d;
	tbe_pkg::mode_t  mode_c, op_q;

	logic [tbe_pkg::LEN_W-1:0] buffer_length_q;
	logic [NW-1:0] len_c, pos_n, len_q, s_q, ra_q, ra_s1, k_q, lo_q, wk_s1;
	logic [NW-1:0] src, srl, ep;
	logic [KW-1:0] pl_c, rl_c, plen_q, rlen_q, d_q, j_q, cnt_q, cnt_nx;
	logic [PW-1:0] pat_q, rep_q;
	logic [PATTERN_MAX*CW-1:0]     hist_q, win;
	logic [(PATTERN_MAX+1)*CW-1:0] win_ext;
	logic          fwd_q, rv_s1, wv_s1, wz_s1, done_q, done_d;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] read_char_q, rdata, mem_wdata;
	logic          succeeded_q;
	logic [tbe_pkg::LEN_W-1:0] end_position_q;
	logic          mem_we, mem_re, hit, issue, shift_act, shift_zero, fill_act;
	logic [AW-1:0] mem_waddr, mem_raddr;

	assign mode_c = tbe_pkg::mode_t'(mode);
	assign pos_n  = NW'(position);
	assign len_c  = (NW'(buffer_length_q) > NW'(BUFFER_DEPTH)) ? NW'(BUFFER_DEPTH)
		: NW'(buffer_length_q);
	assign pl_c   = (pattern_length > KW'(PATTERN_MAX)) ? KW'(PATTERN_MAX) : pattern_length;
	assign rl_c   = (replacement_length > KW'(PATTERN_MAX)) ? KW'(PATTERN_MAX)
		: replacement_length;

	assign win_ext = {hist_q, rdata};
	assign win     = win_ext[PATTERN_MAX*CW-1:0];
	assign cnt_nx  = (cnt_q == KW'(PATTERN_MAX)) ? cnt_q : cnt_q + KW'(1);
	assign issue   = ra_q < len_q;

	assign src        = fwd_q ? (k_q + NW'(d_q)) : (k_q - NW'(d_q));
	assign shift_zero = fwd_q && (src >= len_q);
	assign shift_act  = fwd_q ? (k_q < len_q) : ((k_q >= lo_q) && (k_q < len_q));
	assign fill_act   = (j_q < rlen_q) && ((s_q + NW'(j_q)) < len_q);

	assign srl = s_q + NW'(rlen_q);
	assign ep  = (srl > len_q) ? (len_q - NW'(1)) : (srl - NW'(1));

	assign busy         = state_q != tbe_pkg::ST_IDLE;
	assign done         = done_q;
	assign read_char    = read_char_q;
	assign succeeded    = succeeded_q;
	assign end_position = end_position_q;

	tbe_ram #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	tbe_match #(
		.PM (PATTERN_MAX)
	) u_match (
		.win  (win),
		.pat  (pat_q),
		.plen (plen_q),
		.cnt  (cnt_nx),
		.hit  (hit)
	);

	always_comb begin
		state_d   = state_q;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			tbe_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(BUFFER_DEPTH - 1)) begin
					state_d = tbe_pkg::ST_IDLE;
				end
			end
			tbe_pkg::ST_IDLE: begin
				if (start) begin
					case (mode_c)
						tbe_pkg::MODE_WRITE: begin
							mem_we    = pos_n < len_c;
							mem_waddr = pos_n[AW-1:0];
							mem_wdata = char_value;
							done_d    = 1'b1;
						end
						tbe_pkg::MODE_READ: begin
							if (pos_n < len_c) begin
								mem_re    = 1'b1;
								mem_raddr = pos_n[AW-1:0];
								state_d   = tbe_pkg::ST_RDWAIT;
							end else begin
								done_d = 1'b1;
							end
						end
						tbe_pkg::MODE_INSERT: begin
							if (pos_n < len_c) begin
								state_d = tbe_pkg::ST_PREP;
							end else begin
								done_d = 1'b1;
							end
						end
						tbe_pkg::MODE_DELETE: begin
							state_d = tbe_pkg::ST_SEARCH;
						end
						tbe_pkg::MODE_REPLACE: begin
							if (pl_c != '0) begin
								state_d = tbe_pkg::ST_SEARCH;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			tbe_pkg::ST_RDWAIT: begin
				done_d  = 1'b1;
				state_d = tbe_pkg::ST_IDLE;
			end
			tbe_pkg::ST_SEARCH: begin
				mem_re    = issue;
				mem_raddr = ra_q[AW-1:0];
				if (rv_s1 && hit) begin
					state_d = tbe_pkg::ST_PREP;
				end else if (!rv_s1 && !issue) begin
					done_d  = 1'b1;
					state_d = tbe_pkg::ST_IDLE;
				end
			end
			tbe_pkg::ST_PREP: begin
				state_d = tbe_pkg::ST_SHIFT;
			end
			tbe_pkg::ST_SHIFT: begin
				mem_re    = shift_act && !shift_zero;
				mem_raddr = src[AW-1:0];
				mem_we    = wv_s1;
				mem_waddr = wk_s1[AW-1:0];
				mem_wdata = wz_s1 ? '0 : rdata;
				if (!shift_act && !wv_s1) begin
					state_d = tbe_pkg::ST_FILL;
				end
			end
			tbe_pkg::ST_FILL: begin
				if (fill_act) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(s_q + NW'(j_q));
					mem_wdata = rep_q[{j_q[2:0], 3'b000} +: CW];
				end else begin
					done_d  = 1'b1;
					state_d = tbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= tbe_pkg::ST_CLEAR;
			buffer_length_q <= tbe_pkg::LEN_W'(1024);
			done_q          <= 1'b0;
			rv_s1           <= 1'b0;
			wv_s1           <= 1'b0;
			clr_q           <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			rv_s1   <= (state_q == tbe_pkg::ST_SEARCH) && issue;
			wv_s1   <= (state_q == tbe_pkg::ST_SHIFT) && shift_act;
			if (state_q == tbe_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				buffer_length_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tbe_pkg::ST_IDLE: begin
				if (start) begin
					op_q           <= mode_c;
					len_q          <= len_c;
					s_q            <= pos_n;
					ra_q           <= pos_n;
					cnt_q          <= '0;
					read_char_q    <= '0;
					succeeded_q    <= 1'b0;
					end_position_q <= '0;
					plen_q         <= pl_c;
					rlen_q         <= rl_c;
					pat_q          <= pattern;
					rep_q          <= replacement;
					case (mode_c)
						tbe_pkg::MODE_INSERT: begin
							plen_q <= '0;
							rlen_q <= KW'(1);
							rep_q  <= PW'(char_value);
						end
						tbe_pkg::MODE_DELETE: begin
							plen_q <= KW'(1);
							rlen_q <= '0;
							pat_q  <= PW'(char_value);
						end
						tbe_pkg::MODE_REPLACE: begin
							end_position_q <= '1;
						end
						default: begin
							plen_q <= pl_c;
						end
					endcase
				end
			end
			tbe_pkg::ST_RDWAIT: begin
				read_char_q <= rdata;
			end
			tbe_pkg::ST_SEARCH: begin
				if (rv_s1) begin
					hist_q <= win;
					cnt_q  <= cnt_nx;
				end
				if (issue) begin
					ra_q  <= ra_q + NW'(1);
					ra_s1 <= ra_q;
				end
				if (rv_s1 && hit) begin
					s_q <= ra_s1 - NW'(plen_q) + NW'(1);
				end
			end
			tbe_pkg::ST_PREP: begin
				succeeded_q <= 1'b1;
				end_position_q <= (op_q == tbe_pkg::MODE_REPLACE) ? ep[tbe_pkg::LEN_W-1:0] : '0;
				j_q  <= '0;
				lo_q <= srl;
				if (plen_q > rlen_q) begin
					fwd_q <= 1'b1;
					d_q   <= plen_q - rlen_q;
					k_q   <= srl;
				end else if (rlen_q > plen_q) begin
					fwd_q <= 1'b0;
					d_q   <= rlen_q - plen_q;
					k_q   <= len_q - NW'(1);
				end else begin
					fwd_q <= 1'b1;
					d_q   <= '0;
					k_q   <= len_q;
				end
			end
			tbe_pkg::ST_SHIFT: begin
				if (shift_act) begin
					k_q   <= fwd_q ? (k_q + NW'(1)) : (k_q - NW'(1));
					wk_s1 <= k_q;
					wz_s1 <= shift_zero;
				end
			end
			tbe_pkg::ST_FILL: begin
				if (fill_act) begin
					j_q <= j_q + KW'(1);
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command neither finished nor kept the block busy");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbe_pkg::ST_SHIFT && wv_s1) |-> (wk_s1 < len_q))
		else $error("shift write beyond the length in use");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbe_pkg::ST_FILL && mem_we) |-> ((s_q + NW'(j_q)) < len_q))
		else $error("replacement write beyond the length in use");

	a_window_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tbe_pkg::ST_SEARCH) |-> (cnt_q <= KW'(PATTERN_MAX)))
		else $error("window fill count overran the pattern size");

endmodule
